// File: src/vle_pkg.sv
// vle_pkg: shared types, codes and helpers for the varint encoder
// no dependencies; used by every module of the block

package vle_pkg;

   localparam int VALUE_W     = 64;
   localparam int GROUP_W     = 7;
   localparam int GROUPS      = 8;               // 7-bit groups below the top byte
   localparam int LOW_W       = GROUP_W * GROUPS; // bits 55..0
   localparam int BYTE_W      = 8;
   localparam int IDX_W       = 4;               // byte index 0..8
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_UNSIGNED = 1'b0;
   localparam logic OP_SIGNED   = 1'b1;

   localparam logic [GROUP_W-1:0] FILL_POS  = 7'h00;
   localparam logic [GROUP_W-1:0] FILL_NEG  = 7'h7F;
   localparam logic [BYTE_W-1:0]  EXT_POS   = 8'h00;
   localparam logic [BYTE_W-1:0]  EXT_NEG   = 8'h7F;
   localparam logic [BYTE_W-1:0]  EXT_NEG_9 = 8'hFF;
   localparam logic [BYTE_W-1:0]  TOP_ONES  = 8'hFF;
   localparam logic [BYTE_W-1:0]  TOP_ZERO  = 8'h00;

   // one classified item: low groups, index of the final byte, the final byte itself
   typedef struct packed {
      logic [LOW_W-1:0]  low_bits;
      logic [IDX_W-1:0]  last_idx;
      logic [BYTE_W-1:0] final_byte;
   } vle_entry_type;

   // head of the queue as seen by the back end
   typedef struct packed {
      logic          valid;
      vle_entry_type entry;
   } vle_head_type;

   function automatic logic [GROUP_W-1:0] get_group(input logic [LOW_W-1:0] bits,
                                                    input logic [2:0] idx);
      return bits[idx * GROUP_W +: GROUP_W];
   endfunction

endpackage

// File: src/vle_front.sv
// vle_front: classifies an accepted item into byte count and final byte
// depends on vle_pkg

module vle_front (
   input  logic                          opcode,
   input  logic [vle_pkg::VALUE_W-1:0]   value,
   output vle_pkg::vle_entry_type        entry
);

   logic [vle_pkg::BYTE_W-1:0]  top;
   logic                        pure_sign;
   logic                        signed_mode;
   logic                        neg;
   logic [vle_pkg::GROUP_W-1:0] fill;
   logic [2:0]                  hi;
   logic [vle_pkg::GROUP_W-1:0] grp_hi;
   logic                        ext;

   always_comb begin
      top         = value[vle_pkg::VALUE_W-1 -: vle_pkg::BYTE_W];
      pure_sign   = (top == vle_pkg::TOP_ZERO) || (top == vle_pkg::TOP_ONES);
      signed_mode = (opcode == vle_pkg::OP_SIGNED) && pure_sign;
      neg         = value[vle_pkg::VALUE_W-1];
      fill        = (signed_mode && neg) ? vle_pkg::FILL_NEG : vle_pkg::FILL_POS;

      // highest group that is not fill, group 0 always kept
      hi = 3'd0;
      for (int k = 1; k < vle_pkg::GROUPS; k++) begin
         if (vle_pkg::get_group(value[vle_pkg::LOW_W-1:0], 3'(k)) != fill) begin
            hi = 3'(k);
         end
      end
      grp_hi = vle_pkg::get_group(value[vle_pkg::LOW_W-1:0], hi);
      ext    = signed_mode && (grp_hi[vle_pkg::GROUP_W-1] != neg);

      entry.low_bits = value[vle_pkg::LOW_W-1:0];
      if (!signed_mode && (top != vle_pkg::TOP_ZERO)) begin
         // full nine-byte form, raw top byte last
         entry.last_idx   = vle_pkg::IDX_W'(vle_pkg::GROUPS);
         entry.final_byte = top;
      end else if (ext) begin
         entry.last_idx = vle_pkg::IDX_W'(hi) + 1'b1;
         if (!neg) begin
            entry.final_byte = vle_pkg::EXT_POS;
         end else if (hi == 3'(vle_pkg::GROUPS - 1)) begin
            entry.final_byte = vle_pkg::EXT_NEG_9;
         end else begin
            entry.final_byte = vle_pkg::EXT_NEG;
         end
      end else begin
         entry.last_idx   = vle_pkg::IDX_W'(hi);
         entry.final_byte = {1'b0, grp_hi};
      end
   end

endmodule

// File: src/vle_queue.sv
// vle_queue: short register queue between the front and back ends
// depends on vle_pkg

module vle_queue #(
   parameter int Depth = vle_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  vle_pkg::vle_entry_type push_entry,
   input  logic                   pop,
   output vle_pkg::vle_head_type  head,
   output logic                   full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   vle_pkg::vle_entry_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      head.valid = (count_ff != '0);
      head.entry = mem_ff[rd_ptr_ff];
      full       = (count_ff == CntW'(Depth));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/vle_back.sv
// vle_back: walks a valid queue head one byte per cycle into result registers
// depends on vle_pkg

module vle_back (
   input  logic                        clock,
   input  logic                        reset,
   input  vle_pkg::vle_head_type       head,
   output logic                        pop,
   output logic                        strobe,
   output logic [vle_pkg::BYTE_W-1:0]  out_byte,
   output logic                        last_byte
);

   logic [vle_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       strobe_ff;
   logic                       last_ff;
   logic [vle_pkg::BYTE_W-1:0] byte_ff, byte_in;

   always_comb begin
      pop    = head.valid && (idx_ff == head.entry.last_idx);
      idx_in = idx_ff;
      if (head.valid) begin
         idx_in = pop ? '0 : idx_ff + 1'b1;
      end
      if (pop) begin
         byte_in = head.entry.final_byte;
      end else begin
         // continuation byte, index is below eight here
         byte_in = {1'b1, vle_pkg::get_group(head.entry.low_bits, idx_ff[2:0])};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         strobe_ff <= head.valid;
         last_ff   <= pop;
      end
      byte_ff <= byte_in;
   end

   assign strobe    = strobe_ff;
   assign out_byte  = byte_ff;
   assign last_byte = last_ff;

endmodule

// File: src/varint_encoder.sv
// varint_encoder: top level of the 9-byte-capped leb128-style varint encoder
// depends on vle_pkg, vle_front, vle_queue, vle_back

// An item (req_opcode, req_value) is taken on a clock edge where start is high
// and busy is low. Its code leaves as one byte per cycle on rsp_out_byte, each
// byte marked by rsp_strobe for one cycle, with rsp_last_byte on the final one;
// the receiver cannot stall, so every strobed byte must be taken. A code is
// 1 to 9 bytes long and leaves through the single byte-wide output register
// of the back end. A taken item is first registered in the item queue and
// waits there behind any earlier codes; its first byte is then registered in
// that output register and strobed. Queued items follow each other with no gap.
// busy rises only when the item queue between the front end and the back end
// is full. There is no configuration and no clearing pass after reset.

module varint_encoder #(
   parameter int QueueDepth = vle_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_opcode,
   input  logic [vle_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_strobe,
   output logic [vle_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_byte
);

   vle_pkg::vle_entry_type front_entry;
   vle_pkg::vle_head_type  queue_head;
   logic                   queue_full;
   logic                   queue_pop;
   logic                   accept;

   // item handshake: accepted when start is high and the queue has room
   assign accept = start && !queue_full;
   assign busy   = queue_full;

   // front end: byte count, extension byte and final byte per item
   vle_front u_front (
      .opcode (req_opcode),
      .value  (req_value),
      .entry  (front_entry)
   );

   // decouples classification from byte emission
   vle_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .head       (queue_head),
      .full       (queue_full)
   );

   // back end: one registered byte per cycle while the queue holds an item
   vle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .strobe    (rsp_strobe),
      .out_byte  (rsp_out_byte),
      .last_byte (rsp_last_byte)
   );

endmodule

// File: src/vle_checker.sv
// vle_checker: port-level checks on the varint encoder, bound to the top level
// depends on vle_pkg and varint_encoder

module vle_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [vle_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                        rsp_last_byte
);

   logic [vle_pkg::IDX_W-1:0] run_ff;

   // bytes seen so far in the current code
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (rsp_strobe) begin
         run_ff <= rsp_last_byte ? '0 : run_ff + 1'b1;
      end
   end

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("output or busy active after reset");

   a_cont_bit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_byte) |-> rsp_out_byte[vle_pkg::BYTE_W-1])
      else $error("continuation byte without bit 7");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_byte) |=> rsp_strobe)
      else $error("gap inside a code");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (run_ff == vle_pkg::IDX_W'(vle_pkg::GROUPS))) |-> rsp_last_byte)
      else $error("code longer than nine bytes");

   a_last_strobed: assert property (@(posedge clock) disable iff (reset)
      rsp_last_byte |-> rsp_strobe)
      else $error("final-byte flag without strobe");

endmodule

bind varint_encoder vle_checker u_vle_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last_byte (rsp_last_byte)
);

// File: tb/testbench.sv
// testbench: self-checking bench for varint_encoder, the 9-byte-capped leb128-style encoder
// depends on vle_pkg and the varint_encoder rtl; a built-in byte-code predictor checks each byte

`timescale 1ns / 1ps

module testbench;
   import vle_pkg::*;

   // one value waiting to be sent, with the idle cycles that come before it
   typedef struct {
      logic                opcode;
      logic [VALUE_W-1:0]  value;
      int unsigned         gap;
   } pending_item_type;

   // one byte of a predicted code
   typedef struct {
      logic [BYTE_W-1:0] code_byte;
      logic              last;
   } code_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_opcode = OP_UNSIGNED;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_strobe;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last_byte;

   pending_item_type pending_items[$];
   code_byte_type    expected_bytes[$];
   int unsigned      mismatches = 0;

   // driver bookkeeping
   pending_item_type presented;      // item now on the req ports
   pending_item_type loaded;         // next item, sitting out its idle gap
   logic             have_loaded = 1'b0;
   int unsigned      idle_left = 0;
   logic             next_start;

   varint_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   always #2 clock = ~clock;

   // queue one predicted byte
   function automatic void push_code_byte(input logic [BYTE_W-1:0] b, input logic last);
      code_byte_type c;
      c.code_byte = b;
      c.last      = last;
      expected_bytes.push_back(c);
   endfunction

   // work out the whole byte code of one value and queue it
   function automatic void predict_code(input logic op, input logic [VALUE_W-1:0] v);
      logic [BYTE_W-1:0]  top_byte;
      logic [VALUE_W-1:0] rest;
      logic [VALUE_W-1:0] shifted;
      logic [GROUP_W-1:0] grp;
      logic [GROUP_W-1:0] fill;
      logic [BYTE_W-1:0]  ext_byte;
      logic               neg;
      logic               ext;
      logic               done;
      int                 n;
      int                 sh;
      int                 groups;
      top_byte = v[VALUE_W-1 -: BYTE_W];
      if (op == OP_UNSIGNED || (top_byte != TOP_ZERO && top_byte != TOP_ONES)) begin
         // plain unsigned groups, ninth byte raw when reached
         rest = v;
         done = 1'b0;
         for (n = 0; n < 9 && !done; n++) begin
            if (n == 8) begin
               push_code_byte(rest[BYTE_W-1:0], 1'b1);
               done = 1'b1;
            end else begin
               grp  = rest[GROUP_W-1:0];
               rest = rest >> GROUP_W;
               if (rest == '0) begin
                  push_code_byte({1'b0, grp}, 1'b1);
                  done = 1'b1;
               end else begin
                  push_code_byte({1'b1, grp}, 1'b0);
               end
            end
         end
      end else begin
         // signed with a pure-sign top byte: drop sign-fill groups from the top
         neg  = v[VALUE_W-1];
         fill = neg ? FILL_NEG : FILL_POS;
         sh   = 49;
         shifted = v >> sh;
         while (sh > 0 && shifted[GROUP_W-1:0] == fill) begin
            sh -= GROUP_W;
            shifted = v >> sh;
         end
         grp = shifted[GROUP_W-1:0];
         ext = 1'b0;
         ext_byte = EXT_POS;
         if (neg && !grp[GROUP_W-1]) begin
            ext = 1'b1;
            ext_byte = (sh == 49) ? EXT_NEG_9 : EXT_NEG;
         end else if (!neg && grp[GROUP_W-1]) begin
            ext = 1'b1;
            ext_byte = EXT_POS;
         end
         groups = sh / GROUP_W + 1;
         for (n = 0; n < groups; n++) begin
            shifted = v >> (GROUP_W * n);
            if (n + 1 == groups && !ext)
               push_code_byte({1'b0, shifted[GROUP_W-1:0]}, 1'b1);
            else
               push_code_byte({1'b1, shifted[GROUP_W-1:0]}, 1'b0);
         end
         if (ext)
            push_code_byte(ext_byte, 1'b1);
      end
   endfunction

   // driver: takes items from the pending queue, honors each one's idle gap,
   // and predicts the code of every item the block takes
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         req_opcode <= OP_UNSIGNED;
         req_value  <= '0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            // item taken at this edge
            predict_code(presented.opcode, presented.value);
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (!have_loaded && pending_items.size() > 0) begin
               loaded      = pending_items.pop_front();
               have_loaded = 1'b1;
               idle_left   = loaded.gap;
            end
            if (have_loaded && idle_left == 0) begin
               // present the next item, back to back when it has no gap
               presented   = loaded;
               have_loaded = 1'b0;
               next_start  = 1'b1;
               req_opcode <= loaded.opcode;
               req_value  <= loaded.value;
            end else begin
               if (have_loaded)
                  idle_left--;
               // junk on the idle bus, the block must ignore it
               req_opcode <= 1'($urandom_range(0, 1));
               req_value  <= {$urandom, $urandom};
            end
         end
         start <= next_start;
      end
   end

   // monitor: every strobed byte must match the oldest predicted byte
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_bytes.size() == 0) begin
            $error("out_byte: no byte expected, got %h last_byte %b",
                   rsp_out_byte, rsp_last_byte);
            mismatches++;
         end else begin
            if (rsp_out_byte !== expected_bytes[0].code_byte) begin
               $error("out_byte: expected %h, got %h",
                      expected_bytes[0].code_byte, rsp_out_byte);
               mismatches++;
            end
            if (rsp_last_byte !== expected_bytes[0].last) begin
               $error("last_byte: expected %b, got %b",
                      expected_bytes[0].last, rsp_last_byte);
               mismatches++;
            end
            void'(expected_bytes.pop_front());
         end
      end
   end

   function automatic void add_item(input logic op, input logic [VALUE_W-1:0] v,
                                    input int unsigned gap);
      pending_item_type p;
      p.opcode = op;
      p.value  = v;
      p.gap    = gap;
      pending_items.push_back(p);
   endfunction

   // random value shaped to hit every code length in both modes
   function automatic logic [VALUE_W-1:0] random_value(input logic op);
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] mask;
      int unsigned        kind;
      int unsigned        len;
      v    = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         return v;
      end else if (kind < 8) begin
         // short value, sign-extended half the time in signed mode
         len  = $urandom_range(1, 63);
         mask = (64'd1 << len) - 64'd1;
         v    = v & mask;
         if (op == OP_SIGNED && $urandom_range(0, 1) == 1)
            v = v | ~mask;
         return v;
      end else begin
         // around a power of two, sometimes inverted
         v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
         if ($urandom_range(0, 1) == 1)
            v = ~v;
         return v;
      end
   endfunction

   initial begin
      int unsigned phase;
      int unsigned k;
      int unsigned idle_pct;
      int unsigned gap;
      logic        op;

      // directed: unsigned extremes and group boundaries
      add_item(OP_UNSIGNED, 64'h0, 0);
      add_item(OP_UNSIGNED, 64'h7F, 0);
      add_item(OP_UNSIGNED, 64'h80, 0);
      add_item(OP_UNSIGNED, 64'h3FFF, 0);
      add_item(OP_UNSIGNED, 64'h4000, 0);
      add_item(OP_UNSIGNED, 64'h00FF_FFFF_FFFF_FFFF, 0);
      add_item(OP_UNSIGNED, 64'h0100_0000_0000_0000, 0);
      add_item(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      // signed, pure-sign top byte, no extension
      add_item(OP_SIGNED, 64'h0, 0);
      add_item(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      add_item(OP_SIGNED, 64'h3F, 0);
      add_item(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFC0, 0);
      add_item(OP_SIGNED, 64'hFF80_0000_0000_0000, 0);
      // signed with kept zero groups below the top one
      add_item(OP_SIGNED, 64'h0000_0000_0001_0000, 0);
      add_item(OP_SIGNED, 64'h0000_0000_0000_0080, 0);
      // signed, extension byte: positive, negative short, negative at byte nine
      add_item(OP_SIGNED, 64'h40, 0);
      add_item(OP_SIGNED, 64'h2000, 0);
      add_item(OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFBF, 0);
      add_item(OP_SIGNED, 64'h0080_0000_0000_0000, 0);
      add_item(OP_SIGNED, 64'hFF7F_FFFF_FFFF_FFFF, 0);
      add_item(OP_SIGNED, 64'h00C0_0000_0000_0000, 0);
      // signed, top byte not pure sign: full nine-byte form
      add_item(OP_SIGNED, 64'h0100_0000_0000_0000, 0);
      add_item(OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 0);
      add_item(OP_SIGNED, 64'h8000_0000_0000_0000, 0);
      add_item(OP_SIGNED, 64'hFEFF_FFFF_FFFF_FFFF, 0);

      // random part in four phases of sender idling: none, 48, none, 26
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            1: begin
               idle_pct = 48;
            end
            3: begin
               idle_pct = 26;
            end
            default: begin
               idle_pct = 0;
            end
         endcase
         for (k = 0; k < 75; k++) begin
            op  = 1'($urandom_range(0, 1));
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
            add_item(op, random_value(op), gap);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // drain: all items taken and every predicted byte seen
      @(negedge clock);
      while (pending_items.size() > 0 || have_loaded || start || expected_bytes.size() > 0)
         @(negedge clock);
      // a few more cycles to catch stray bytes
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
